// File: rtl/wfmc_pkg.sv
// Shared types, constants and the rule match function for the wildcard classifier.
package wfmc_pkg;

   localparam int RuleSlots  = 64;
   localparam int IndexWidth = $clog2(RuleSlots);
   localparam int GroupSize  = 8;
   localparam int Groups     = RuleSlots / GroupSize;
   localparam int KeyWidth   = 8;
   localparam int PortWidth  = 8;
   localparam int CountWidth = 7;

   localparam logic [KeyWidth-1:0] WildcardKey = KeyWidth'(42);

   localparam logic ModeLoad   = 1'b0;
   localparam logic ModeLookup = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [IndexWidth-1:0] rule_index;
      logic [KeyWidth-1:0]   first_key;
      logic [KeyWidth-1:0]   second_key;
      logic [PortWidth-1:0]  port_value;
   } req_type;

   typedef struct packed {
      logic [PortWidth-1:0] out_port;
      logic                 dropped;
   } rsp_type;

   typedef struct packed {
      logic [KeyWidth-1:0]  key_a;
      logic [KeyWidth-1:0]  key_b;
      logic [PortWidth-1:0] port;
   } rule_type;

   // first hit of one group of rules
   typedef struct packed {
      logic                 found;
      logic [PortWidth-1:0] port;
   } group_type;

   function automatic logic rule_hit(input rule_type r,
                                     input logic [KeyWidth-1:0] ka,
                                     input logic [KeyWidth-1:0] kb);
      logic a_eq;
      logic b_eq;
      a_eq = (r.key_a == ka);
      b_eq = (r.key_b == kb);
      return (a_eq && b_eq) ||
             ((r.key_a == WildcardKey) && b_eq) ||
             (a_eq && (r.key_b == WildcardKey));
   endfunction

endpackage

// File: rtl/wildcard_first_match_classifier_top.sv
// Top level of the two-field first-match wildcard classifier.
//
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one request per
//   accepted edge. mode = load writes the rule {first_key, second_key,
//   port_value} into slot rule_index and returns nothing. mode = lookup
//   searches the rules below rule_count in slot order and returns one
//   response on the rsp channel: the port of the first matching rule, or
//   dropped = 1 with out_port = 0.
//   csr channel (csr_valid / csr_ready / csr_data) writes rule_count. It is
//   always ready; write it only while no request is in flight.
//   Throughput: one request per cycle unless a stall backs up, set by the
//   three register stages (input register, per-group first-hit stage,
//   output register); a lookup shows rsp_valid once through all three.
//   Reset (synchronous, active high) clears rule_count and all valid bits.
//   The rule table is not cleared; a lookup must only reach slots that
//   were loaded. A stalled response holds; the stall backs up stage by
//   stage, and req_stall rises only when the input register cannot move.
module wildcard_first_match_classifier_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  wfmc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wfmc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wfmc_pkg::CountWidth-1:0]     csr_data
);

   // configuration
   logic [wfmc_pkg::CountWidth-1:0] rule_count_ff;

   // rule table, one register per slot, each compared by its own cell
   wfmc_pkg::rule_type table_ff [wfmc_pkg::RuleSlots];

   // stage 0: input register
   logic              s0_valid_ff;
   wfmc_pkg::req_type s0_ff;
   // stage 1: per-group first hit
   logic                s1_valid_ff;
   wfmc_pkg::group_type s1_ff [wfmc_pkg::Groups];
   wfmc_pkg::group_type s1_in [wfmc_pkg::Groups];
   // stage 2: output register
   logic              rsp_valid_ff;
   wfmc_pkg::rsp_type rsp_ff;
   wfmc_pkg::rsp_type rsp_in;

   logic s2_ready;
   logic s1_ready;
   logic s0_ready;
   logic s0_fire;
   logic s1_fire;
   logic [wfmc_pkg::Groups-1:0] s1_found;

   // stage enables: a stage moves when it is empty or the next one moves
   assign s2_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign s0_fire   = s0_valid_ff && s1_ready;
   assign s1_fire   = s1_valid_ff && s2_ready;
   assign req_stall = !s0_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         rule_count_ff <= csr_data;
      end
   end

   // Loads write as they leave stage 0, the same point where lookups
   // compare, so every lookup sees exactly the loads ahead of it.
   always_ff @(posedge clock) begin
      if (s0_fire && (s0_ff.mode == wfmc_pkg::ModeLoad)) begin
         table_ff[s0_ff.rule_index] <= '{key_a: s0_ff.first_key,
                                         key_b: s0_ff.second_key,
                                         port:  s0_ff.port_value};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_valid) begin
         s0_ff <= req_data;
      end
   end

   // compare all cells, lowest matching slot of each group wins
   always_comb begin
      for (int g = 0; g < wfmc_pkg::Groups; g++) begin
         s1_in[g] = '{found: 1'b0, port: '0};
         for (int j = wfmc_pkg::GroupSize - 1; j >= 0; j--) begin
            if (((g * wfmc_pkg::GroupSize + j) < int'(rule_count_ff)) &&
                wfmc_pkg::rule_hit(table_ff[g * wfmc_pkg::GroupSize + j],
                                   s0_ff.first_key, s0_ff.second_key)) begin
               s1_in[g] = '{found: 1'b1,
                            port:  table_ff[g * wfmc_pkg::GroupSize + j].port};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s0_valid_ff && (s0_ff.mode == wfmc_pkg::ModeLookup);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
   end

   // combine groups, lowest group wins
   always_comb begin
      rsp_in = '{out_port: '0, dropped: 1'b1};
      for (int g = wfmc_pkg::Groups - 1; g >= 0; g--) begin
         s1_found[g] = s1_ff[g].found;
         if (s1_ff[g].found) begin
            rsp_in = '{out_port: s1_ff[g].port, dropped: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_drop_zero_port: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.dropped) |-> (rsp_ff.out_port == '0))
      else $error("dropped response with nonzero port");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s0_valid_ff && s1_valid_ff && rsp_valid_ff))
      else $error("input stalled with room in the pipeline");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (s0_fire && (s0_ff.mode == wfmc_pkg::ModeLoad)) |=> !s1_valid_ff)
      else $error("load request produced a lookup slot");

   a_drop_matches_hits: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (rsp_valid_ff && (rsp_ff.dropped == ($past(s1_found) == '0))))
      else $error("dropped flag disagrees with group hits");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_found)))
      else $error("stalled stage 1 lost its contents");

endmodule
